// ===== src/page_frame_bitmap_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_defines
// Assertion macros used by the page frame allocator sources.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define PFBA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PFBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFBA_ASSERT(lbl, clk, rst, prop, msg)
`define PFBA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== src/pfba_pkg.sv =====
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared types and constants of the page frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

  localparam int ROW_BITS = 64;
  localparam int BIT_W    = $clog2(ROW_BITS);
  localparam int CNT_W    = 13;
  localparam int IDX_W    = 12;

  localparam logic [CNT_W-1:0] CNT_MAX     = 13'h1FFF;
  localparam logic [CNT_W-1:0] TOTAL_RESET = 13'd4096;

  typedef enum logic [2:0] {
    REQ_GET    = 3'd0,
    REQ_LOCK   = 3'd1,
    REQ_FREE   = 3'd2,
    REQ_RESV   = 3'd3,
    REQ_UNRESV = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_SAME  = 2'd1,
    ST_NONE  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

// ===== src/pfba_ram.sv =====
// ----------------------------------------------------------------------------
// pfba_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/pfba_find.sv =====
// ----------------------------------------------------------------------------
// pfba_find
// Lowest clear bit of one bitmap row.
// ----------------------------------------------------------------------------
module pfba_find (
  input  logic [pfba_pkg::ROW_BITS-1:0] word,
  output logic                          found,
  output logic [pfba_pkg::BIT_W-1:0]    index
);

  always_comb begin
    found = ~&word;
    index = '0;
    for (int b = pfba_pkg::ROW_BITS - 1; b >= 0; b--) begin
      if (!word[b]) begin
        index = pfba_pkg::BIT_W'(b);
      end
    end
  end

endmodule

// ===== src/page_frame_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// First-fit physical page allocator over a busy bitmap held in RAM.
//
// Input channel (in_valid/in_stall) carries req_type and page_index; every
// beat gives exactly one result beat on the output channel (out_valid/
// out_stall). The user must write total_pages through cfg_write/cfg_data
// only while idle; the block itself does not enforce this. The bitmap sits
// in a RAM of 64-bit rows, read-modify-write one row at a time. Lock, free,
// reserve and unreserve pass through S_MOD to S_EMIT; out of range and
// unknown types go straight to S_EMIT. A get request scans one row per cycle
// through the single RAM read port. One item is in flight at a time. After
// reset a clearing pass writes every row to zero, one row a cycle, with
// in_stall high; configuration writes are taken during it. The result sits
// in an output register, so a new item is accepted while the receiver
// stalls the previous result; a finished item then waits until that
// register is free.
// ----------------------------------------------------------------------------
`include "page_frame_bitmap_allocator_defines.svh"

module page_frame_bitmap_allocator #(
  parameter int PAGES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [pfba_pkg::CNT_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  req_type,
  input  logic [pfba_pkg::IDX_W-1:0]  page_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pfba_pkg::IDX_W-1:0]  granted_page,
  output logic [1:0]                  status,
  output logic [pfba_pkg::CNT_W-1:0]  used_pages,
  output logic [pfba_pkg::CNT_W-1:0]  reserved_pages,
  output logic [pfba_pkg::CNT_W-1:0]  avail_pages
);

  localparam int ROWS  = (PAGES + pfba_pkg::ROW_BITS - 1) / pfba_pkg::ROW_BITS;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PG_W  = ROW_W + 1 + pfba_pkg::BIT_W;
  localparam int CW    = (PG_W > pfba_pkg::CNT_W + 1) ? PG_W : pfba_pkg::CNT_W + 1;
  localparam logic [CW-1:0]    PAGES_C  = CW'(PAGES);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t                         state;
  logic [ROW_W-1:0]               clr_row;
  logic [ROW_W:0]                 issue_cnt;
  logic                           chk_valid;
  logic [ROW_W-1:0]               chk_row;
  logic [2:0]                     req_kind;
  logic [pfba_pkg::IDX_W-1:0]     req_idx;
  logic [pfba_pkg::IDX_W-1:0]     pend_granted;
  pfba_pkg::status_t              pend_status;
  logic [pfba_pkg::CNT_W-1:0]     used_cnt;
  logic [pfba_pkg::CNT_W-1:0]     resv_cnt;
  logic [pfba_pkg::CNT_W-1:0]     total_reg;

  logic [pfba_pkg::CNT_W-1:0]     lim;
  logic [CW-1:0]                  lim_c;
  logic [CW-1:0]                  issue_base;
  logic [CW-1:0]                  chk_base;
  logic [CW-1:0]                  lim_rem;
  logic                           issue_ok;
  logic [pfba_pkg::ROW_BITS-1:0]  tail_mask;
  logic [pfba_pkg::ROW_BITS-1:0]  bit_sel;
  logic [pfba_pkg::ROW_BITS-1:0]  find_sel;
  logic                           find_found;
  logic [pfba_pkg::BIT_W-1:0]     find_index;
  logic                           cur_bit;
  logic                           setting;
  logic [pfba_pkg::CNT_W-1:0]     used_inc;
  logic [pfba_pkg::CNT_W-1:0]     used_dec;
  logic [pfba_pkg::CNT_W-1:0]     resv_inc;
  logic [pfba_pkg::CNT_W-1:0]     resv_dec;
  logic [pfba_pkg::CNT_W:0]       taken;
  logic [pfba_pkg::CNT_W-1:0]     free_calc;

  logic                           ram_we;
  logic [ROW_W-1:0]               ram_waddr;
  logic [pfba_pkg::ROW_BITS-1:0]  ram_wdata;
  logic [ROW_W-1:0]               ram_raddr;
  logic [pfba_pkg::ROW_BITS-1:0]  ram_rdata;

  assign in_stall = (state != S_IDLE);

  // active limit is the smaller of total_pages and PAGES
  assign lim   = (CW'(total_reg) < PAGES_C) ? total_reg : pfba_pkg::CNT_W'(PAGES_C);
  assign lim_c = CW'(lim);

  assign issue_base = CW'({issue_cnt, {pfba_pkg::BIT_W{1'b0}}});
  assign chk_base   = CW'({chk_row, {pfba_pkg::BIT_W{1'b0}}});
  assign issue_ok   = (issue_base < lim_c);
  assign lim_rem    = lim_c - chk_base;

  // pages at or above the limit look busy to the search
  assign tail_mask = (lim_rem >= CW'(pfba_pkg::ROW_BITS)) ? '0 :
                     ({pfba_pkg::ROW_BITS{1'b1}} << lim_rem[pfba_pkg::BIT_W-1:0]);

  pfba_find u_find (
    .word  (ram_rdata | tail_mask),
    .found (find_found),
    .index (find_index)
  );

  assign bit_sel  = pfba_pkg::ROW_BITS'(1) << req_idx[pfba_pkg::BIT_W-1:0];
  assign find_sel = pfba_pkg::ROW_BITS'(1) << find_index;
  assign cur_bit  = ram_rdata[req_idx[pfba_pkg::BIT_W-1:0]];
  assign setting  = (req_kind == pfba_pkg::REQ_LOCK) || (req_kind == pfba_pkg::REQ_RESV);

  assign used_inc = (used_cnt == pfba_pkg::CNT_MAX) ? used_cnt : used_cnt + 1'b1;
  assign used_dec = (used_cnt == '0) ? used_cnt : used_cnt - 1'b1;
  assign resv_inc = (resv_cnt == pfba_pkg::CNT_MAX) ? resv_cnt : resv_cnt + 1'b1;
  assign resv_dec = (resv_cnt == '0) ? resv_cnt : resv_cnt - 1'b1;

  assign taken     = {1'b0, used_cnt} + {1'b0, resv_cnt};
  assign free_calc = ({1'b0, lim} > taken) ?
                     pfba_pkg::CNT_W'({1'b0, lim} - taken) : '0;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_row;
    ram_wdata = '0;
    ram_raddr = ROW_W'(page_index >> pfba_pkg::BIT_W);
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_row;
      end
      S_MOD: begin
        ram_we    = (cur_bit != setting);
        ram_waddr = ROW_W'(req_idx >> pfba_pkg::BIT_W);
        ram_wdata = setting ? (ram_rdata | bit_sel) : (ram_rdata & ~bit_sel);
      end
      S_SCAN: begin
        ram_raddr = issue_cnt[ROW_W-1:0];
        ram_we    = chk_valid && find_found;
        ram_wdata = ram_rdata | find_sel;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  pfba_ram #(
    .WIDTH (pfba_pkg::ROW_BITS),
    .DEPTH (ROWS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_row   <= '0;
      issue_cnt <= '0;
      chk_valid <= 1'b0;
      used_cnt  <= '0;
      resv_cnt  <= '0;
      total_reg <= pfba_pkg::TOTAL_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        total_reg <= cfg_data;
      end
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == LAST_ROW) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_kind     <= req_type;
            req_idx      <= page_index;
            pend_granted <= page_index;
            issue_cnt    <= '0;
            chk_valid    <= 1'b0;
            case (req_type)
              pfba_pkg::REQ_GET: begin
                state <= S_SCAN;
              end
              pfba_pkg::REQ_LOCK, pfba_pkg::REQ_FREE,
              pfba_pkg::REQ_RESV, pfba_pkg::REQ_UNRESV: begin
                if (CW'(page_index) >= lim_c) begin
                  pend_status <= pfba_pkg::ST_RANGE;
                  state       <= S_EMIT;
                end else begin
                  state <= S_MOD;
                end
              end
              default: begin
                pend_status <= pfba_pkg::ST_SAME;
                state       <= S_EMIT;
              end
            endcase
          end
        end
        S_MOD: begin
          if (cur_bit == setting) begin
            pend_status <= pfba_pkg::ST_SAME;
          end else begin
            pend_status <= pfba_pkg::ST_DONE;
            case (req_kind)
              pfba_pkg::REQ_LOCK: begin
                used_cnt <= used_inc;
              end
              pfba_pkg::REQ_FREE: begin
                used_cnt <= used_dec;
              end
              pfba_pkg::REQ_RESV: begin
                resv_cnt <= resv_inc;
              end
              default: begin
                resv_cnt <= resv_dec;
              end
            endcase
          end
          state <= S_EMIT;
        end
        S_SCAN: begin
          // one row read issued per cycle, checked in the cycle after
          chk_valid <= issue_ok && !(chk_valid && find_found);
          chk_row   <= issue_cnt[ROW_W-1:0];
          if (issue_ok) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (chk_valid && find_found) begin
            pend_granted <= pfba_pkg::IDX_W'({chk_row, find_index});
            pend_status  <= pfba_pkg::ST_DONE;
            used_cnt     <= used_inc;
            state        <= S_EMIT;
          end else if (!chk_valid && !issue_ok) begin
            pend_status <= pfba_pkg::ST_NONE;
            state       <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            granted_page   <= pend_granted;
            status         <= pend_status;
            used_pages     <= used_cnt;
            reserved_pages <= resv_cnt;
            avail_pages    <= free_calc;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PFBA_ASSERT(a_clear_done, clk, rst, (state == S_CLEAR && clr_row == LAST_ROW) |=> (state == S_IDLE), "clearing pass did not end at the last row")
  `PFBA_ASSERT(a_idle_counts, clk, rst, (state == S_IDLE) |=> ($stable(used_cnt) && $stable(resv_cnt)), "counts changed while idle")
  `PFBA_ASSERT(a_scan_claim, clk, rst, (state == S_SCAN && ram_we) |=> (state == S_EMIT && pend_status == pfba_pkg::ST_DONE), "scan write without a granted page")
  `PFBA_ASSERT(a_mod_flip, clk, rst, (state == S_MOD && ram_we) |=> (pend_status == pfba_pkg::ST_DONE), "bit flipped without done status")

endmodule
